[src/motor_command_frame_encoder_assert.svh]
// ------------------------------------------------------------------------
// Assertion macros for the motor command frame encoder
// Shared concurrent checks, clocked on clk and held off while rst_n is low.
// ------------------------------------------------------------------------
`ifndef MOTOR_COMMAND_FRAME_ENCODER_ASSERT_SVH
`define MOTOR_COMMAND_FRAME_ENCODER_ASSERT_SVH

// condition must hold at every edge
`define MCFE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define MCFE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define MCFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/mcfe_pkg.sv]
// ------------------------------------------------------------------------
// mcfe_pkg
// Types, constants and helper functions of the motor command frame encoder.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcfe_pkg;

  localparam int FRAC_BITS = 20;            // fraction bits of set_value
  localparam int VALUE_W   = 36;
  localparam int KIND_W    = 3;
  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 32;
  localparam int LIMV_W    = 15;            // holds the largest limit, 20000
  localparam int SCALE_W   = 20;            // holds the largest scale, 1e6
  localparam int MAG_W     = FRAC_BITS + LIMV_W;
  localparam int LIM_W     = MAG_W + 1;
  localparam int CMP_W     = ((VALUE_W > LIM_W) ? VALUE_W : LIM_W) + 1;
  localparam int MULA_W    = FRAC_BITS + 9; // duty, current, pos: <= 360 << FRAC_BITS
  localparam int PROD_W    = MULA_W + SCALE_W;

  localparam int NUM_CODES = 5;
  localparam int CFG_IDX_W = 3;

  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  localparam logic [BYTE_W-1:0] FRAME_START   = 8'h02;
  localparam logic [BYTE_W-1:0] FRAME_END     = 8'h03;
  localparam logic [BYTE_W-1:0] LEN_NO_DATA   = 8'h01;
  localparam logic [BYTE_W-1:0] LEN_WITH_DATA = 8'h05;
  localparam logic [15:0]       CRC_POLY      = 16'h1021;

  typedef enum logic [KIND_W-1:0] {
    KIND_GET_VALUES  = 3'd0,
    KIND_SET_DUTY    = 3'd1,
    KIND_SET_CURRENT = 3'd2,
    KIND_SET_RPM     = 3'd3,
    KIND_SET_POS     = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CODE_GET_VALUES  = 3'd0,
    REG_CODE_SET_DUTY    = 3'd1,
    REG_CODE_SET_CURRENT = 3'd2,
    REG_CODE_SET_RPM     = 3'd3,
    REG_CODE_SET_POS     = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_LEN,
    ST_CODE,
    ST_DATA,
    ST_CRC_HI,
    ST_CRC_LO,
    ST_END
  } state_t;

  typedef logic [NUM_CODES-1:0][BYTE_W-1:0] codes_t;

  // one classified command, front to back
  typedef struct packed {
    logic              get;
    logic [BYTE_W-1:0] code;
    logic [WORD_W-1:0] word;
  } cmd_t;

  localparam codes_t CODE_RESET = {8'd9, 8'd8, 8'd6, 8'd5, 8'd4};

  function automatic logic [LIMV_W-1:0] lim_of(kind_t k);
    logic [LIMV_W-1:0] l;
    case (k)
      KIND_SET_DUTY:    l = 15'd100;
      KIND_SET_CURRENT: l = 15'd30;
      KIND_SET_RPM:     l = 15'd20000;
      KIND_SET_POS:     l = 15'd360;
      default:          l = '0;
    endcase
    return l;
  endfunction

  function automatic logic [SCALE_W-1:0] scale_of(kind_t k);
    logic [SCALE_W-1:0] s;
    case (k)
      KIND_SET_DUTY:    s = 20'd1000;
      KIND_SET_CURRENT: s = 20'd1000;
      KIND_SET_POS:     s = 20'd1000000;
      default:          s = 20'd1;
    endcase
    return s;
  endfunction

  // CRC-16 XMODEM, one byte, MSB first
  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [BYTE_W-1:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

[src/mcfe_front.sv]
// ------------------------------------------------------------------------
// mcfe_front
// Accepts commands, drops unknown kinds, clamps, scales and truncates.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcfe_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mcfe_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [mcfe_pkg::VALUE_W-1:0] in_set_value,
  input  mcfe_pkg::codes_t                    codes,
  output logic                                push_valid,
  input  logic                                push_ready,
  output mcfe_pkg::cmd_t                      push_cmd
);

  // stage A: clamped magnitude
  logic                               va_r, va_nxt;
  mcfe_pkg::kind_t                    kind_a_r;
  logic [mcfe_pkg::BYTE_W-1:0]        code_a_r;
  logic                               neg_a_r;
  logic [mcfe_pkg::MAG_W-1:0]         mag_a_r;
  // stage B: scaled product
  logic                               vb_r, vb_nxt;
  logic                               get_b_r;
  logic [mcfe_pkg::BYTE_W-1:0]        code_b_r;
  logic                               neg_b_r;
  logic [mcfe_pkg::PROD_W-1:0]        prod_b_r;

  logic                               en;
  logic                               known;
  mcfe_pkg::kind_t                    kind_in;
  logic [mcfe_pkg::BYTE_W-1:0]        code_in;
  logic signed [mcfe_pkg::CMP_W-1:0]  val_s, lim_s, nlim_s, clamp_s, abs_s;
  logic [mcfe_pkg::PROD_W-1:0]        prod_nxt;
  logic [mcfe_pkg::WORD_W-1:0]        word_mag;

  assign en       = !vb_r || push_ready;
  assign in_ready = en;
  assign kind_in  = mcfe_pkg::kind_t'(in_kind);

  always_comb begin
    known   = 1'b1;
    code_in = codes[0];
    case (kind_in)
      mcfe_pkg::KIND_GET_VALUES:  code_in = codes[0];
      mcfe_pkg::KIND_SET_DUTY:    code_in = codes[1];
      mcfe_pkg::KIND_SET_CURRENT: code_in = codes[2];
      mcfe_pkg::KIND_SET_RPM:     code_in = codes[3];
      mcfe_pkg::KIND_SET_POS:     code_in = codes[4];
      default:                    known   = 1'b0;
    endcase
  end

  // clamp to +-limit << FRAC_BITS
  always_comb begin
    val_s  = $signed({{(mcfe_pkg::CMP_W - mcfe_pkg::VALUE_W){in_set_value[mcfe_pkg::VALUE_W-1]}},
                      in_set_value});
    lim_s  = $signed(mcfe_pkg::CMP_W'(mcfe_pkg::lim_of(kind_in)) << mcfe_pkg::FRAC_BITS);
    nlim_s = -lim_s;
    if (val_s > lim_s) begin
      clamp_s = lim_s;
    end else if (val_s < nlim_s) begin
      clamp_s = nlim_s;
    end else begin
      clamp_s = val_s;
    end
    abs_s = clamp_s[mcfe_pkg::CMP_W-1] ? -clamp_s : clamp_s;
  end

  assign va_nxt = en ? (in_valid && known) : va_r;
  assign vb_nxt = en ? va_r : vb_r;

  // rpm has scale one: bypass the multiplier with the wider magnitude
  assign prod_nxt = (kind_a_r == mcfe_pkg::KIND_SET_RPM)
                  ? mcfe_pkg::PROD_W'(mag_a_r)
                  : mcfe_pkg::PROD_W'(mag_a_r[mcfe_pkg::MULA_W-1:0])
                    * mcfe_pkg::PROD_W'(mcfe_pkg::scale_of(kind_a_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_a_r <= kind_in;
      code_a_r <= code_in;
      neg_a_r  <= clamp_s[mcfe_pkg::CMP_W-1];
      mag_a_r  <= mcfe_pkg::MAG_W'(abs_s);
      get_b_r  <= (kind_a_r == mcfe_pkg::KIND_GET_VALUES);
      code_b_r <= code_a_r;
      neg_b_r  <= neg_a_r;
      prod_b_r <= prod_nxt;
    end
  end

  // truncate toward zero: shift the magnitude, then reapply the sign
  assign word_mag        = mcfe_pkg::WORD_W'(prod_b_r >> mcfe_pkg::FRAC_BITS);
  assign push_valid      = vb_r;
  assign push_cmd.get    = get_b_r;
  assign push_cmd.code   = code_b_r;
  assign push_cmd.word   = neg_b_r ? (~word_mag + 1'b1) : word_mag;

endmodule

[src/mcfe_queue.sv]
// ------------------------------------------------------------------------
// mcfe_queue
// Two-entry command queue between front and back.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "motor_command_frame_encoder_assert.svh"

module mcfe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  mcfe_pkg::cmd_t wr_cmd,
  output logic           rd_valid,
  input  logic           rd_ready,
  output mcfe_pkg::cmd_t rd_cmd
);

  mcfe_pkg::cmd_t              slot_r [mcfe_pkg::QDEPTH];
  logic [mcfe_pkg::QPTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [mcfe_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        push, pop;

  assign wr_ready = (cnt_r != mcfe_pkg::QCNT_W'(mcfe_pkg::QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = slot_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wr_cmd;
    end
  end

  `MCFE_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= mcfe_pkg::QCNT_W'(mcfe_pkg::QDEPTH), "queue overfilled")
  `MCFE_ASSERT_IMPL(a_ptr_gap, cnt_r == '0, wptr_r == rptr_r, "empty queue with pointer gap")

endmodule

[src/mcfe_back.sv]
// ------------------------------------------------------------------------
// mcfe_back
// Serialises one command into frame beats with a running CRC.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "motor_command_frame_encoder_assert.svh"

module mcfe_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  mcfe_pkg::cmd_t              cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mcfe_pkg::BYTE_W-1:0] out_frame_byte,
  output logic                        out_last
);

  mcfe_pkg::state_t            state_r, state_nxt;
  mcfe_pkg::cmd_t              cmd_r;
  logic [1:0]                  dcnt_r, dcnt_nxt;
  logic [15:0]                 crc_r, crc_nxt;
  logic                        ovalid_r, ovalid_nxt;
  logic [mcfe_pkg::BYTE_W-1:0] obyte_r;
  logic                        olast_r;

  logic                        load, emit, pop;
  logic [mcfe_pkg::BYTE_W-1:0] byte_val;
  logic                        last_val, crc_feed;

  assign load = !ovalid_r || out_ready;
  assign emit = (state_r != mcfe_pkg::ST_IDLE) && load;
  assign pop  = cmd_valid && ((state_r == mcfe_pkg::ST_IDLE) ||
                              (state_r == mcfe_pkg::ST_END && emit));
  assign cmd_ready = (state_r == mcfe_pkg::ST_IDLE) || (state_r == mcfe_pkg::ST_END && emit);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mcfe_pkg::ST_IDLE:   if (cmd_valid) state_nxt = mcfe_pkg::ST_START;
      mcfe_pkg::ST_START:  if (emit) state_nxt = mcfe_pkg::ST_LEN;
      mcfe_pkg::ST_LEN:    if (emit) state_nxt = mcfe_pkg::ST_CODE;
      mcfe_pkg::ST_CODE: begin
        if (emit) state_nxt = cmd_r.get ? mcfe_pkg::ST_CRC_HI : mcfe_pkg::ST_DATA;
      end
      mcfe_pkg::ST_DATA:   if (emit && dcnt_r == 2'd3) state_nxt = mcfe_pkg::ST_CRC_HI;
      mcfe_pkg::ST_CRC_HI: if (emit) state_nxt = mcfe_pkg::ST_CRC_LO;
      mcfe_pkg::ST_CRC_LO: if (emit) state_nxt = mcfe_pkg::ST_END;
      mcfe_pkg::ST_END: begin
        if (emit) state_nxt = cmd_valid ? mcfe_pkg::ST_START : mcfe_pkg::ST_IDLE;
      end
      default:             state_nxt = mcfe_pkg::ST_IDLE;
    endcase
  end

  // beat contents per state
  always_comb begin
    byte_val = mcfe_pkg::FRAME_START;
    last_val = 1'b0;
    crc_feed = 1'b0;
    case (state_r)
      mcfe_pkg::ST_START:  byte_val = mcfe_pkg::FRAME_START;
      mcfe_pkg::ST_LEN:    byte_val = cmd_r.get ? mcfe_pkg::LEN_NO_DATA : mcfe_pkg::LEN_WITH_DATA;
      mcfe_pkg::ST_CODE: begin
        byte_val = cmd_r.code;
        crc_feed = 1'b1;
      end
      mcfe_pkg::ST_DATA: begin
        byte_val = cmd_r.word[(3 - dcnt_r) * mcfe_pkg::BYTE_W +: mcfe_pkg::BYTE_W];
        crc_feed = 1'b1;
      end
      mcfe_pkg::ST_CRC_HI: byte_val = crc_r[15:8];
      mcfe_pkg::ST_CRC_LO: byte_val = crc_r[7:0];
      mcfe_pkg::ST_END: begin
        byte_val = mcfe_pkg::FRAME_END;
        last_val = 1'b1;
      end
      default:             byte_val = mcfe_pkg::FRAME_START;
    endcase
  end

  always_comb begin
    crc_nxt    = crc_r;
    dcnt_nxt   = dcnt_r;
    ovalid_nxt = load ? emit : ovalid_r;
    if (pop) begin
      crc_nxt  = '0;
      dcnt_nxt = '0;
    end else if (emit && crc_feed) begin
      crc_nxt = mcfe_pkg::crc_step(crc_r, byte_val);
      if (state_r == mcfe_pkg::ST_DATA) dcnt_nxt = dcnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mcfe_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
      dcnt_r   <= '0;
      crc_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      dcnt_r   <= dcnt_nxt;
      crc_r    <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= cmd;
    end
    if (emit) begin
      obyte_r <= byte_val;
      olast_r <= last_val;
    end
  end

  assign out_valid      = ovalid_r;
  assign out_frame_byte = obyte_r;
  assign out_last       = olast_r;

  `MCFE_ASSERT_IMPL(a_last_is_end, out_valid && out_last, out_frame_byte == mcfe_pkg::FRAME_END,
                    "last beat is not the end marker")
  `MCFE_ASSERT_IMPL(a_no_data_for_get, state_r == mcfe_pkg::ST_DATA, !cmd_r.get,
                    "data beats for a get values frame")
  `MCFE_ASSERT_NEXT(a_start_after_pop, pop, state_r == mcfe_pkg::ST_START && crc_r == '0,
                    "frame did not open cleanly after pop")

endmodule

[src/motor_command_frame_encoder.sv]
// ------------------------------------------------------------------------
// motor_command_frame_encoder
// Turns motor commands into framed byte streams with a CRC-16 XMODEM.
// ------------------------------------------------------------------------
// Each input beat is one command: get values, set duty, set current, set
// rpm or set position, with a signed Q15.20 value (fraction width set by
// mcfe_pkg::FRAC_BITS). The value is clamped per command, scaled and
// truncated toward zero to a 32-bit word, then sent one byte per output
// beat: 0x02, length, code, four big-endian data bytes (left out for get
// values), CRC high, CRC low, 0x03 with out_last set. Kinds 5 to 7 are
// dropped without output. A frame is 10 beats (6 for get values) and the
// serialiser sends one beat per cycle while out_ready is high; frames
// follow each other with no gap while the queue holds the next command.
// The first byte passes through both front stages, the queue, the frame
// start state of the serialiser and the output register. A two-entry
// queue lets the front keep taking commands while the back is still busy
// or stalled. Command codes are written over the cfg port (index 0 to 4);
// the user must write them only while idle, which the block itself does
// not enforce. Writes to other indices are ignored. cfg_ready is always high.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_command_frame_encoder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [mcfe_pkg::KIND_W-1:0]           in_kind,
  input  logic signed [mcfe_pkg::VALUE_W-1:0]   in_set_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [mcfe_pkg::BYTE_W-1:0]           out_frame_byte,
  output logic                                  out_last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mcfe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mcfe_pkg::BYTE_W-1:0]           cfg_data
);

  // command code registers
  mcfe_pkg::codes_t codes_r, codes_nxt;

  logic             q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
  mcfe_pkg::cmd_t   q_wr_cmd, q_rd_cmd;

  assign cfg_ready = 1'b1;

  always_comb begin
    codes_nxt = codes_r;
    if (cfg_valid) begin
      case (mcfe_pkg::reg_idx_t'(cfg_index))
        mcfe_pkg::REG_CODE_GET_VALUES:  codes_nxt[0] = cfg_data;
        mcfe_pkg::REG_CODE_SET_DUTY:    codes_nxt[1] = cfg_data;
        mcfe_pkg::REG_CODE_SET_CURRENT: codes_nxt[2] = cfg_data;
        mcfe_pkg::REG_CODE_SET_RPM:     codes_nxt[3] = cfg_data;
        mcfe_pkg::REG_CODE_SET_POS:     codes_nxt[4] = cfg_data;
        default:                        codes_nxt    = codes_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r <= mcfe_pkg::CODE_RESET;
    end else begin
      codes_r <= codes_nxt;
    end
  end

  // front: accept, classify, clamp and scale
  mcfe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_set_value (in_set_value),
    .codes        (codes_r),
    .push_valid   (q_wr_valid),
    .push_ready   (q_wr_ready),
    .push_cmd     (q_wr_cmd)
  );

  mcfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_cmd   (q_wr_cmd),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_cmd   (q_rd_cmd)
  );

  // back: frame serialiser with CRC and output register
  mcfe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (q_rd_valid),
    .cmd_ready      (q_rd_ready),
    .cmd            (q_rd_cmd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_last       (out_last)
  );

endmodule

[test/motor_command_frame_encoder_checker.sv]
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// Frame checker for the motor command frame encoder
// Watches the cfg, command and frame channels, builds the expected frame
// bytes for every accepted command of a known kind and compares each output beat in order.
// ------------------------------------------------------------------------

module motor_command_frame_encoder_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [mcfe_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [mcfe_pkg::VALUE_W-1:0] in_set_value,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [mcfe_pkg::BYTE_W-1:0]         out_frame_byte,
  input  logic                                out_last,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [mcfe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mcfe_pkg::BYTE_W-1:0]         cfg_data,
  output int                                  fail_count,
  output int                                  frame_pending,
  output int                                  beats_checked,
  output int                                  frames_checked
);
  import mcfe_pkg::*;

  localparam int MAX_PRINTS = 30;
  localparam logic [BYTE_W-1:0] CODES_AT_RESET [NUM_CODES] = '{8'd4, 8'd5, 8'd6, 8'd8, 8'd9};

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } frame_beat_t;

  logic [BYTE_W-1:0] code_tab [NUM_CODES];
  frame_beat_t       expected_beats [$];

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTS)
      $display("mismatch @%0t: %s", $time, msg);
  endtask

  function automatic int clamp_whole(kind_t k);
    case (k)
      KIND_SET_DUTY:    return 100;
      KIND_SET_CURRENT: return 30;
      KIND_SET_RPM:     return 20000;
      KIND_SET_POS:     return 360;
      default:          return 0;
    endcase
  endfunction

  function automatic longint unsigned scale_mult(kind_t k);
    case (k)
      KIND_SET_DUTY, KIND_SET_CURRENT: return 1000;
      KIND_SET_POS:                    return 1000000;
      default:                         return 1;
    endcase
  endfunction

  // clamp, scale, truncate toward zero, back to two's complement
  function automatic logic [WORD_W-1:0] command_word(kind_t k, logic signed [VALUE_W-1:0] raw);
    longint            v;
    longint            lim;
    longint unsigned   mag;
    longint unsigned   prod;
    logic [WORD_W-1:0] w;
    v   = raw;
    lim = longint'(clamp_whole(k)) <<< FRAC_BITS;
    if (v > lim) v = lim;
    else if (v < -lim) v = -lim;
    mag  = (v < 0) ? longint'(-v) : v;
    prod = (mag * scale_mult(k)) >> FRAC_BITS;
    w    = prod[WORD_W-1:0];
    if (v < 0) w = ~w + 1'b1;
    return w;
  endfunction

  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [BYTE_W-1:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    return c;
  endfunction

  function automatic void push_beat(logic [BYTE_W-1:0] b, logic is_last);
    frame_beat_t fb;
    fb.data = b;
    fb.last = is_last;
    expected_beats.push_back(fb);
  endfunction

  function automatic void predict_frame(logic [KIND_W-1:0] k, logic signed [VALUE_W-1:0] v);
    logic [BYTE_W-1:0] body [5];
    logic [WORD_W-1:0] w;
    logic [15:0]       crc;
    int                n;
    if (k > KIND_SET_POS) return;       // unknown kinds are dropped
    body[0] = code_tab[k];
    n = 1;
    if (k != KIND_GET_VALUES) begin
      w = command_word(kind_t'(k), v);
      body[1] = w[31:24];
      body[2] = w[23:16];
      body[3] = w[15:8];
      body[4] = w[7:0];
      n = 5;
    end
    push_beat(FRAME_START, 1'b0);
    push_beat((n == 1) ? LEN_NO_DATA : LEN_WITH_DATA, 1'b0);
    crc = 16'h0000;
    for (int i = 0; i < n; i++) begin
      crc = crc16_update(crc, body[i]);
      push_beat(body[i], 1'b0);
    end
    push_beat(crc[15:8], 1'b0);
    push_beat(crc[7:0], 1'b0);
    push_beat(FRAME_END, 1'b1);
  endfunction

  always @(posedge clk) begin
    frame_beat_t want;
    if (!rst_n) begin
      code_tab = CODES_AT_RESET;
      expected_beats.delete();
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < NUM_CODES)
        code_tab[cfg_index] = cfg_data;
      // pop before push so a new command never matches a beat of this edge
      if (out_valid && out_ready) begin
        beats_checked++;
        if (out_last) frames_checked++;
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat byte=%02h last=%0b",
                                    out_frame_byte, out_last));
        end else begin
          want = expected_beats.pop_front();
          if (out_frame_byte !== want.data)
            report_mismatch($sformatf("frame_byte %02h, want %02h",
                                      out_frame_byte, want.data));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b (byte %02h)",
                                      out_last, want.last, want.data));
        end
      end
      if (in_valid && in_ready)
        predict_frame(in_kind, in_set_value);
    end
    frame_pending = expected_beats.size();
  end

endmodule

[test/tb_motor_command_frame_encoder.sv]
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// Testbench for motor_command_frame_encoder
// Drives directed and random motor commands through several code-register
// settings with random idling on both sides and a long output stall; a
// separate checker predicts every frame byte and counts mismatches.
// ------------------------------------------------------------------------

module tb_motor_command_frame_encoder;
  import mcfe_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;    // front stages + queue + out reg, with margin
  localparam int HOLD_CYCLES   = 300;   // long output stall

  // kinds and register indexes the block must ignore
  localparam logic [KIND_W-1:0]    KIND_FIRST_UNUSED = 3'd5;
  localparam logic [KIND_W-1:0]    KIND_LAST_UNUSED  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED   = 3'd7;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [KIND_W-1:0]           in_kind;
  logic signed [VALUE_W-1:0]   in_set_value;
  logic                        out_valid;
  logic                        out_ready;
  logic [BYTE_W-1:0]           out_frame_byte;
  logic                        out_last;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [BYTE_W-1:0]           cfg_data;

  int fail_count;
  int frame_pending;
  int beats_checked;
  int frames_checked;

  int send_idle_pct = 35;
  int recv_idle_pct = 35;
  int stall_reqs    = 0;
  int stall_served  = 0;
  int cmds_sent     = 0;
  int cfg_writes    = 0;
  int cycle_count   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  motor_command_frame_encoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_set_value   (in_set_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  motor_command_frame_encoder_checker u_frame_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_set_value   (in_set_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .frame_pending  (frame_pending),
    .beats_checked  (beats_checked),
    .frames_checked (frames_checked)
  );

  // Whole-unit value in the block's fixed-point format.
  function automatic logic signed [VALUE_W-1:0] fixed_whole(longint whole);
    return VALUE_W'(whole <<< FRAC_BITS);
  endfunction

  // Clamp bound used only to shape stimulus; get values and unknown kinds borrow the duty range.
  function automatic int stim_limit(logic [KIND_W-1:0] k);
    case (k)
      KIND_SET_CURRENT: return 30;
      KIND_SET_RPM:     return 20000;
      KIND_SET_POS:     return 360;
      default:          return 100;
    endcase
  endfunction

  // Mostly valid kinds, a few unknown ones.
  function automatic logic [KIND_W-1:0] pick_kind();
    if ($urandom_range(0, 99) < 8)
      return KIND_FIRST_UNUSED + KIND_W'($urandom_range(0, 2));
    return KIND_W'($urandom_range(KIND_GET_VALUES, KIND_SET_POS));
  endfunction

  // Value mix: raw 36-bit noise, in range, small fractions, near the clamp,
  // the field extremes and whole numbers.
  function automatic logic signed [VALUE_W-1:0] pick_value(logic [KIND_W-1:0] k);
    int                        lim;
    longint                    lim_fix;
    longint unsigned           r;
    logic signed [VALUE_W-1:0] v;
    lim     = stim_limit(k);
    lim_fix = longint'(lim) <<< FRAC_BITS;
    r       = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = r[VALUE_W-1:0];
      1: v = VALUE_W'(longint'(r % longint'(2 * lim_fix + 1)) - lim_fix);
      2: begin
        v = VALUE_W'(longint'($urandom_range(0, 1 << 22)));
        if ($urandom_range(0, 1)) v = -v;
      end
      3: v = VALUE_W'(($urandom_range(0, 1) ? lim_fix : -lim_fix)
                      + longint'($urandom_range(0, 4)) - 2);
      4: v = $urandom_range(0, 1) ? 36'sh7_FFFF_FFFF : 36'sh8_0000_0000;
      default: v = fixed_whole(longint'($urandom_range(0, 2 * lim)) - lim);
    endcase
    return v;
  endfunction

  // One command beat. Called at a falling edge; returns at the falling edge
  // after acceptance with in_valid still high, so a following beat can go
  // straight out without a bubble.
  task automatic send_cmd(input logic [KIND_W-1:0] k, input logic signed [VALUE_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= k;
    in_set_value <= v;
    do @(posedge clk); while (!in_ready);
    cmds_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every frame is out; unknown kinds leave no
  // trace in the checker, so give the pipeline a few more cycles too.
  task automatic settle();
    in_valid <= 1'b0;
    wait (frame_pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Write all five code registers, either one fill value or random bytes.
  task automatic program_codes(input logic [BYTE_W-1:0] fill, input bit randomise);
    reg_idx_t r;
    r = r.first();
    repeat (NUM_CODES) begin
      cfg_write(r, randomise ? BYTE_W'($urandom) : fill);
      r = r.next();
    end
  endtask

  task automatic run_random(input int n);
    logic [KIND_W-1:0] k;
    repeat (n) begin
      k = pick_kind();
      send_cmd(k, pick_value(k));
    end
  endtask

  // Output side: random back-pressure, plus a long hold-off on request.
  initial begin
    int held;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_served < stall_reqs) begin
        out_ready <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
        stall_served++;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [KIND_W-1:0] k;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_kind      = '0;
    in_set_value = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed, reset codes ---
    send_cmd(KIND_GET_VALUES,  36'shF_FFFF_FFFF);        // value ignored
    send_cmd(KIND_SET_DUTY,    '0);
    send_cmd(KIND_SET_DUTY,    36'sh7_FFFF_FFFF);        // clamps high
    send_cmd(KIND_SET_DUTY,    36'sh8_0000_0000);        // clamps low
    send_cmd(KIND_SET_DUTY,    fixed_whole(100));        // exactly on the bound
    send_cmd(KIND_SET_DUTY,    -36'sd1);                 // truncates to zero
    send_cmd(KIND_SET_DUTY,    36'sd1 <<< (FRAC_BITS - 1));           // one half
    send_cmd(KIND_SET_DUTY,    -((36'sd1 <<< (FRAC_BITS - 1)) + 1));  // just past -0.5
    send_cmd(KIND_SET_CURRENT, 36'sh7_FFFF_FFFF);
    send_cmd(KIND_SET_CURRENT, fixed_whole(-30));
    send_cmd(KIND_SET_CURRENT, 36'sd12345678);
    send_cmd(KIND_SET_RPM,     36'sh7_FFFF_FFFF);
    send_cmd(KIND_SET_RPM,     36'sh8_0000_0000);
    send_cmd(KIND_SET_RPM,     -36'sd1);
    send_cmd(KIND_SET_RPM,     36'sd3 <<< (FRAC_BITS - 1));           // 1.5 rpm
    send_cmd(KIND_SET_POS,     36'sh7_FFFF_FFFF);
    send_cmd(KIND_SET_POS,     36'sh8_0000_0000);
    send_cmd(KIND_SET_POS,     36'sd1);                  // below one micro-degree
    send_cmd(KIND_SET_POS,     fixed_whole(-359) - 36'sd12345);
    send_cmd(KIND_FIRST_UNUSED,     fixed_whole(5));     // unknown kinds: no frame
    send_cmd(KIND_FIRST_UNUSED + KIND_W'(1), 36'sh8_0000_0000);
    send_cmd(KIND_LAST_UNUSED,      36'sh7_FFFF_FFFF);
    send_cmd(KIND_GET_VALUES,  '0);
    settle();

    // --- all codes zero, plus a write to an index that does not exist ---
    program_codes(8'h00, 1'b0);
    cfg_write(REG_FIRST_UNUSED, BYTE_W'($urandom));
    run_random(80);
    settle();

    // --- all codes 0xFF ---
    program_codes(8'hFF, 1'b0);
    cfg_write(REG_LAST_UNUSED, 8'hFF);
    cfg_write(REG_FIRST_UNUSED + CFG_IDX_W'(1), 8'h00);
    run_random(80);
    settle();

    // --- random codes; no idling on either side, then a long output
    // stall while commands keep coming so the block backs up ---
    program_codes(8'h00, 1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 100; i++) begin
      if (i == 6) stall_reqs++;
      if (i == 60) begin
        send_idle_pct = 35;
        recv_idle_pct = 35;
      end
      k = pick_kind();
      send_cmd(k, pick_value(k));
    end
    settle();

    // --- fresh random codes, long random tail ---
    program_codes(8'h00, 1'b1);
    run_random(120);
    settle();

    $display("summary: %0d commands (every kind, clamped, in range, unknown), %0d cfg writes",
             cmds_sent, cfg_writes);
    $display("summary: %0d frame beats in %0d frames checked, %0d mismatches",
             beats_checked, frames_checked, fail_count);
    if (fail_count == 0 && frame_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/mcfe_pkg.sv
src/mcfe_front.sv
src/mcfe_queue.sv
src/mcfe_back.sv
src/motor_command_frame_encoder.sv
test/motor_command_frame_encoder_checker.sv
test/tb_motor_command_frame_encoder.sv
